@@ src/cpt_pkg.sv @@
// shared constants, types and functions of the clarke/park current transform
package cpt_pkg;

   localparam int CURRENT_WIDTH    = 16;
   localparam int ANGLE_WIDTH      = 16;
   localparam int SINE_TABLE_DEPTH = 1024;

   localparam int OFFSET_WIDTH   = 16;
   localparam int POLE_WIDTH     = 6;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   localparam logic [OFFSET_WIDTH-1:0] ANGLE_OFFSET_RESET = 16'd2316;
   localparam logic [POLE_WIDTH-1:0]   POLE_PAIRS_RESET   = 6'd7;

   // register index taken from paddr[2]
   localparam logic REG_ANGLE_OFFSET = 1'b0;
   localparam logic REG_POLE_PAIRS   = 1'b1;

   localparam int NUM_STAGES = 6;

   localparam int QUARTER_BITS  = ANGLE_WIDTH - 2;
   localparam int SINE_IDX_BITS = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int SINE_BITS     = 15;
   localparam int SINE_SHIFT    = 15;
   localparam int Q30_SHIFT     = 30;

   localparam logic signed [31:0] THIRD_Q30     = 32'sd357913941;
   localparam logic signed [31:0] INV_SQRT3_Q30 = 32'sd619925131;
   localparam logic [63:0]        HALF_PI_Q30   = 64'd1686629713;
   localparam logic [63:0]        SINE_ONE      = 64'd32767;

   localparam int SAT_IN_WIDTH = CURRENT_WIDTH + 8;
   localparam longint CURRENT_MAX = (64'sd1 <<< (CURRENT_WIDTH - 1)) - 64'sd1;
   localparam longint CURRENT_MIN = -CURRENT_MAX - 64'sd1;

   localparam int TAYLOR_TERMS = 10;
   localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420
   };

   typedef logic [SINE_BITS-1:0] sine_rom_type [0:SINE_TABLE_DEPTH];

   // register enables of the six pipeline stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
      logic s5;
      logic s6;
   } stage_load_type;

   // quarter-wave lookup result for one angle
   typedef struct packed {
      logic [SINE_BITS-1:0] sin_mag;
      logic [SINE_BITS-1:0] cos_mag;
      logic                 sin_neg;
      logic                 cos_neg;
   } trig_type;

   // quarter-wave sine table, taylor series in q1.30, evaluated at elaboration
   function automatic sine_rom_type build_sine_table();
      sine_rom_type      tbl;
      logic [63:0]       x;
      logic [63:0]       x2;
      logic [63:0]       term;
      logic signed [63:0] sum;
      logic [63:0]       scaled;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x = (HALF_PI_Q30 * 64'(k) + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
         x2 = (x * x) >> Q30_SHIFT;
         term = x;
         sum = $signed(x);
         for (int n = 1; n <= TAYLOR_TERMS; n++) begin
            term = ((term * x2) >> Q30_SHIFT) / TAYLOR_DIV[n-1];
            if (n % 2 == 1) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
         end
         if (sum < 0) begin
            sum = 64'sd0;
         end
         if (sum > (64'sd1 <<< Q30_SHIFT)) begin
            sum = 64'sd1 <<< Q30_SHIFT;
         end
         scaled = ($unsigned(sum) * SINE_ONE + (64'd1 << (Q30_SHIFT - 1))) >> Q30_SHIFT;
         tbl[k] = scaled[SINE_BITS-1:0];
      end
      return tbl;
   endfunction

   function automatic logic signed [CURRENT_WIDTH-1:0] sat_current(
      input logic signed [SAT_IN_WIDTH-1:0] v
   );
      logic signed [SAT_IN_WIDTH-1:0] hi;
      logic signed [SAT_IN_WIDTH-1:0] lo;
      hi = SAT_IN_WIDTH'(CURRENT_MAX);
      lo = SAT_IN_WIDTH'(CURRENT_MIN);
      if (v > hi) begin
         return hi[CURRENT_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[CURRENT_WIDTH-1:0];
      end
      return v[CURRENT_WIDTH-1:0];
   endfunction

endpackage

@@ src/clarke_park_current_transform.sv @@
// top level of the clarke/park current transform: registers, pipeline control, datapath
// Takes one sample of three phase currents and a rotor angle per clock, unless req_stall
// is high, and returns the clarke (alpha, beta) and park (d, q) currents, saturated to 16
// bits, with the electrical angle used for the rotation. The pipeline is six register
// stages deep and sustains one item per clock while the output is not stalled; the stages
// are the clarke sums, the clarke and angle multiplies, rounding plus the sine/cosine
// table read, the four park multiplies, the park sums, and rounding with saturation into
// the output register. A stalled output holds its item and stages upstream keep filling
// empty slots until the pipeline is full. Sine and cosine come from a 1025-entry
// quarter-wave rom with two registered read ports. angle_offset and pole_pairs are
// written through the apb port at byte addresses 0 and 4 and must only change while no
// item is in flight.
module clarke_park_current_transform (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  req_phase_u_current,
   input  logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  req_phase_v_current,
   input  logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  req_phase_w_current,
   input  logic [cpt_pkg::ANGLE_WIDTH-1:0]           req_rotor_angle,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  rsp_alpha_current,
   output logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  rsp_beta_current,
   output logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  rsp_direct_current,
   output logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  rsp_quadrature_current,
   output logic [cpt_pkg::ANGLE_WIDTH-1:0]           rsp_electrical_angle,
   input  logic                                      psel,
   input  logic                                      penable,
   input  logic                                      pwrite,
   input  logic [cpt_pkg::CSR_ADDR_WIDTH-1:0]        paddr,
   input  logic [cpt_pkg::CSR_DATA_WIDTH-1:0]        pwdata,
   output logic [cpt_pkg::CSR_DATA_WIDTH-1:0]        prdata,
   output logic                                      pready
);

   localparam int NS = cpt_pkg::NUM_STAGES;

   logic [cpt_pkg::OFFSET_WIDTH-1:0] angle_offset_ff;
   logic [cpt_pkg::POLE_WIDTH-1:0]   pole_pairs_ff;
   logic                             csr_write;

   logic [NS-1:0] valid_ff, valid_in, load;
   cpt_pkg::stage_load_type stage_load;

   logic signed [cpt_pkg::CURRENT_WIDTH-1:0] clarke_alpha, clarke_beta;
   logic [cpt_pkg::ANGLE_WIDTH-1:0]          trig_elec;
   cpt_pkg::trig_type                        trig;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_offset_ff <= cpt_pkg::ANGLE_OFFSET_RESET;
         pole_pairs_ff   <= cpt_pkg::POLE_PAIRS_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            cpt_pkg::REG_ANGLE_OFFSET: begin
               angle_offset_ff <= pwdata[cpt_pkg::OFFSET_WIDTH-1:0];
            end
            cpt_pkg::REG_POLE_PAIRS: begin
               pole_pairs_ff <= pwdata[cpt_pkg::POLE_WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         cpt_pkg::REG_ANGLE_OFFSET: prdata = cpt_pkg::CSR_DATA_WIDTH'(angle_offset_ff);
         cpt_pkg::REG_POLE_PAIRS:   prdata = cpt_pkg::CSR_DATA_WIDTH'(pole_pairs_ff);
         default:                   prdata = '0;
      endcase
   end

   // a stage loads when it is empty or the stage after it moves on
   always_comb begin
      load[NS-1] = !valid_ff[NS-1] || !rsp_stall;
      for (int i = NS - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in[0] = req_valid;
      for (int i = 1; i < NS; i++) begin
         valid_in[i] = valid_ff[i-1];
      end
      stage_load.s1 = load[0];
      stage_load.s2 = load[1];
      stage_load.s3 = load[2];
      stage_load.s4 = load[3];
      stage_load.s5 = load[4];
      stage_load.s6 = load[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (load[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[NS-1];

   cpt_clarke u_clarke (
      .clock           (clock),
      .stage_load      (stage_load),
      .phase_u_current (req_phase_u_current),
      .phase_v_current (req_phase_v_current),
      .phase_w_current (req_phase_w_current),
      .alpha_current   (clarke_alpha),
      .beta_current    (clarke_beta)
   );

   cpt_angle u_angle (
      .clock            (clock),
      .stage_load       (stage_load),
      .rotor_angle      (req_rotor_angle),
      .angle_offset     (angle_offset_ff),
      .pole_pairs       (pole_pairs_ff),
      .electrical_angle (trig_elec),
      .trig             (trig)
   );

   cpt_park u_park (
      .clock              (clock),
      .stage_load         (stage_load),
      .alpha_in_current   (clarke_alpha),
      .beta_in_current    (clarke_beta),
      .elec_in_angle      (trig_elec),
      .trig               (trig),
      .alpha_current      (rsp_alpha_current),
      .beta_current       (rsp_beta_current),
      .direct_current     (rsp_direct_current),
      .quadrature_current (rsp_quadrature_current),
      .electrical_angle   (rsp_electrical_angle)
   );

endmodule

@@ src/cpt_clarke.sv @@
// clarke transform pipeline: phase currents to saturated alpha and beta
module cpt_clarke (
   input  logic                                       clock,
   input  cpt_pkg::stage_load_type                    stage_load,
   input  logic signed [cpt_pkg::CURRENT_WIDTH-1:0]   phase_u_current,
   input  logic signed [cpt_pkg::CURRENT_WIDTH-1:0]   phase_v_current,
   input  logic signed [cpt_pkg::CURRENT_WIDTH-1:0]   phase_w_current,
   output logic signed [cpt_pkg::CURRENT_WIDTH-1:0]   alpha_current,
   output logic signed [cpt_pkg::CURRENT_WIDTH-1:0]   beta_current
);

   localparam int ANUM_W = cpt_pkg::CURRENT_WIDTH + 2;
   localparam int BNUM_W = cpt_pkg::CURRENT_WIDTH + 1;
   localparam int PROD_W = ANUM_W + 32;
   localparam int RND_W  = PROD_W - cpt_pkg::Q30_SHIFT;
   localparam longint Q30_HALF = 64'sd1 <<< (cpt_pkg::Q30_SHIFT - 1);

   logic signed [ANUM_W-1:0] anum_in, anum_ff;
   logic signed [BNUM_W-1:0] bnum_in, bnum_ff;
   logic signed [PROD_W-1:0] aprod_in, aprod_ff;
   logic signed [PROD_W-1:0] bprod_in, bprod_ff;
   logic signed [PROD_W-1:0] abias, bbias;
   logic signed [cpt_pkg::CURRENT_WIDTH-1:0] alpha_in, alpha_ff;
   logic signed [cpt_pkg::CURRENT_WIDTH-1:0] beta_in, beta_ff;

   always_comb begin
      anum_in = (ANUM_W'(phase_u_current) <<< 1) - ANUM_W'(phase_v_current)
                - ANUM_W'(phase_w_current);
      bnum_in = BNUM_W'(phase_v_current) - BNUM_W'(phase_w_current);
      aprod_in = PROD_W'(anum_ff) * PROD_W'(cpt_pkg::THIRD_Q30);
      bprod_in = PROD_W'(bnum_ff) * PROD_W'(cpt_pkg::INV_SQRT3_Q30);
      // ties away from zero: negative values take one less of the half
      abias = aprod_ff + PROD_W'(Q30_HALF) - PROD_W'(aprod_ff[PROD_W-1]);
      bbias = bprod_ff + PROD_W'(Q30_HALF) - PROD_W'(bprod_ff[PROD_W-1]);
      alpha_in = cpt_pkg::sat_current(
         cpt_pkg::SAT_IN_WIDTH'($signed(abias[PROD_W-1:cpt_pkg::Q30_SHIFT])));
      beta_in = cpt_pkg::sat_current(
         cpt_pkg::SAT_IN_WIDTH'($signed(bbias[PROD_W-1:cpt_pkg::Q30_SHIFT])));
   end

   always_ff @(posedge clock) begin
      if (stage_load.s1) begin
         anum_ff <= anum_in;
         bnum_ff <= bnum_in;
      end
      if (stage_load.s2) begin
         aprod_ff <= aprod_in;
         bprod_ff <= bprod_in;
      end
      if (stage_load.s3) begin
         alpha_ff <= alpha_in;
         beta_ff  <= beta_in;
      end
   end

   assign alpha_current = alpha_ff;
   assign beta_current  = beta_ff;

endmodule

@@ src/cpt_angle.sv @@
// electrical angle and quarter-wave sine/cosine lookup pipeline
module cpt_angle (
   input  logic                                 clock,
   input  cpt_pkg::stage_load_type              stage_load,
   input  logic [cpt_pkg::ANGLE_WIDTH-1:0]      rotor_angle,
   input  logic [cpt_pkg::OFFSET_WIDTH-1:0]     angle_offset,
   input  logic [cpt_pkg::POLE_WIDTH-1:0]       pole_pairs,
   output logic [cpt_pkg::ANGLE_WIDTH-1:0]      electrical_angle,
   output cpt_pkg::trig_type                    trig
);

   localparam int AW      = cpt_pkg::ANGLE_WIDTH;
   localparam int QB      = cpt_pkg::QUARTER_BITS;
   localparam int IW      = cpt_pkg::SINE_IDX_BITS;
   localparam int SCALE_W = QB + IW;
   localparam int MUL_W   = AW + cpt_pkg::POLE_WIDTH;
   localparam cpt_pkg::sine_rom_type SINE_ROM = cpt_pkg::build_sine_table();

   logic [AW-1:0]      diff_in, diff_ff;
   logic [MUL_W-1:0]   elec_prod;
   logic [AW-1:0]      elec_ff, elec3_ff;
   logic [1:0]         sin_quad, cos_quad;
   logic [QB-1:0]      frac;
   logic [SCALE_W-1:0] scaled;
   logic [SCALE_W-1:0] rounded;
   logic [IW-1:0]      idx;
   logic [IW-1:0]      sin_addr, cos_addr;
   cpt_pkg::trig_type  trig_ff;

   always_comb begin
      diff_in = rotor_angle - AW'(angle_offset);
      elec_prod = MUL_W'(diff_ff) * MUL_W'(pole_pairs);
      sin_quad = elec_ff[AW-1:AW-2];
      cos_quad = sin_quad + 2'd1;
      frac = elec_ff[QB-1:0];
      scaled = SCALE_W'(frac) * SCALE_W'(cpt_pkg::SINE_TABLE_DEPTH)
               + SCALE_W'(1 << (QB - 1));
      rounded = scaled >> QB;
      if (rounded > SCALE_W'(cpt_pkg::SINE_TABLE_DEPTH)) begin
         idx = IW'(cpt_pkg::SINE_TABLE_DEPTH);
      end else begin
         idx = rounded[IW-1:0];
      end
      // odd quadrants read the table mirrored
      sin_addr = sin_quad[0] ? IW'(cpt_pkg::SINE_TABLE_DEPTH) - idx : idx;
      cos_addr = cos_quad[0] ? IW'(cpt_pkg::SINE_TABLE_DEPTH) - idx : idx;
   end

   always_ff @(posedge clock) begin
      if (stage_load.s1) begin
         diff_ff <= diff_in;
      end
      if (stage_load.s2) begin
         elec_ff <= elec_prod[AW-1:0];
      end
      if (stage_load.s3) begin
         trig_ff.sin_mag <= SINE_ROM[sin_addr];
         trig_ff.cos_mag <= SINE_ROM[cos_addr];
         trig_ff.sin_neg <= sin_quad[1];
         trig_ff.cos_neg <= cos_quad[1];
         elec3_ff        <= elec_ff;
      end
   end

   assign electrical_angle = elec3_ff;
   assign trig             = trig_ff;

endmodule

@@ src/cpt_park.sv @@
// park rotation pipeline with rounding, saturation and the output register
module cpt_park (
   input  logic                                      clock,
   input  cpt_pkg::stage_load_type                   stage_load,
   input  logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  alpha_in_current,
   input  logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  beta_in_current,
   input  logic [cpt_pkg::ANGLE_WIDTH-1:0]           elec_in_angle,
   input  cpt_pkg::trig_type                         trig,
   output logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  alpha_current,
   output logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  beta_current,
   output logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  direct_current,
   output logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  quadrature_current,
   output logic [cpt_pkg::ANGLE_WIDTH-1:0]           electrical_angle
);

   localparam int CW     = cpt_pkg::CURRENT_WIDTH;
   localparam int AW     = cpt_pkg::ANGLE_WIDTH;
   localparam int TRIG_W = cpt_pkg::SINE_BITS + 1;
   localparam int PROD_W = TRIG_W + CW;
   localparam int SUM_W  = PROD_W + 1;
   localparam longint SINE_HALF = 64'sd1 <<< (cpt_pkg::SINE_SHIFT - 1);

   logic signed [TRIG_W-1:0] sin_val, cos_val;
   logic signed [PROD_W-1:0] cos_alpha_in, cos_alpha_ff;
   logic signed [PROD_W-1:0] sin_beta_in, sin_beta_ff;
   logic signed [PROD_W-1:0] cos_beta_in, cos_beta_ff;
   logic signed [PROD_W-1:0] sin_alpha_in, sin_alpha_ff;
   logic signed [SUM_W-1:0]  d_sum_in, d_sum_ff;
   logic signed [SUM_W-1:0]  q_sum_in, q_sum_ff;
   logic signed [SUM_W-1:0]  d_bias, q_bias;
   logic signed [CW-1:0]     d_in, d_ff, q_in, q_ff;
   logic signed [CW-1:0]     alpha4_ff, beta4_ff, alpha5_ff, beta5_ff, alpha6_ff, beta6_ff;
   logic [AW-1:0]            elec4_ff, elec5_ff, elec6_ff;

   always_comb begin
      sin_val = trig.sin_neg ? -$signed({1'b0, trig.sin_mag}) : $signed({1'b0, trig.sin_mag});
      cos_val = trig.cos_neg ? -$signed({1'b0, trig.cos_mag}) : $signed({1'b0, trig.cos_mag});
      cos_alpha_in = PROD_W'(cos_val) * PROD_W'(alpha_in_current);
      sin_beta_in  = PROD_W'(sin_val) * PROD_W'(beta_in_current);
      cos_beta_in  = PROD_W'(cos_val) * PROD_W'(beta_in_current);
      sin_alpha_in = PROD_W'(sin_val) * PROD_W'(alpha_in_current);
      d_sum_in = SUM_W'(cos_alpha_ff) + SUM_W'(sin_beta_ff);
      q_sum_in = SUM_W'(cos_beta_ff) - SUM_W'(sin_alpha_ff);
      // ties away from zero: negative sums take one less of the half
      d_bias = d_sum_ff + SUM_W'(SINE_HALF) - SUM_W'(d_sum_ff[SUM_W-1]);
      q_bias = q_sum_ff + SUM_W'(SINE_HALF) - SUM_W'(q_sum_ff[SUM_W-1]);
      d_in = cpt_pkg::sat_current(
         cpt_pkg::SAT_IN_WIDTH'($signed(d_bias[SUM_W-1:cpt_pkg::SINE_SHIFT])));
      q_in = cpt_pkg::sat_current(
         cpt_pkg::SAT_IN_WIDTH'($signed(q_bias[SUM_W-1:cpt_pkg::SINE_SHIFT])));
   end

   always_ff @(posedge clock) begin
      if (stage_load.s4) begin
         cos_alpha_ff <= cos_alpha_in;
         sin_beta_ff  <= sin_beta_in;
         cos_beta_ff  <= cos_beta_in;
         sin_alpha_ff <= sin_alpha_in;
         alpha4_ff    <= alpha_in_current;
         beta4_ff     <= beta_in_current;
         elec4_ff     <= elec_in_angle;
      end
      if (stage_load.s5) begin
         d_sum_ff  <= d_sum_in;
         q_sum_ff  <= q_sum_in;
         alpha5_ff <= alpha4_ff;
         beta5_ff  <= beta4_ff;
         elec5_ff  <= elec4_ff;
      end
      if (stage_load.s6) begin
         d_ff      <= d_in;
         q_ff      <= q_in;
         alpha6_ff <= alpha5_ff;
         beta6_ff  <= beta5_ff;
         elec6_ff  <= elec5_ff;
      end
   end

   assign alpha_current      = alpha6_ff;
   assign beta_current       = beta6_ff;
   assign direct_current     = d_ff;
   assign quadrature_current = q_ff;
   assign electrical_angle   = elec6_ff;

endmodule

@@ src/cpt_checker.sv @@
// port-level assertions of the clarke/park current transform and their bind
module cpt_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      req_stall,
   input logic                                      rsp_valid,
   input logic                                      rsp_stall,
   input logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  rsp_alpha_current,
   input logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  rsp_beta_current,
   input logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  rsp_direct_current,
   input logic signed [cpt_pkg::CURRENT_WIDTH-1:0]  rsp_quadrature_current,
   input logic [cpt_pkg::ANGLE_WIDTH-1:0]           rsp_electrical_angle
);

   // pipeline comes out of reset empty and ready
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // input only backs up while a valid output item is stalled
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled output item");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled output item dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_alpha_current) && $stable(rsp_beta_current)
         && $stable(rsp_direct_current) && $stable(rsp_quadrature_current)
         && $stable(rsp_electrical_angle))
      else $error("stalled output item changed");

endmodule

bind clarke_park_current_transform cpt_checker u_cpt_checker (.*);
